### src/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/fmo_pkg.sv
// types, constants and preset voice table of the fm register translator
package fmo_pkg;

   typedef struct packed {
      logic [5:0] src_register;
      logic [7:0] write_value;
   } req_type;

   typedef struct packed {
      logic [8:0] target_address;
      logic [7:0] target_data;
      logic       last_write;
   } rsp_type;

   typedef enum logic [1:0] {
      CHIP_NONE = 2'd0,
      CHIP_BASE = 2'd1,
      CHIP_BOTH = 2'd2
   } chip_mode_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_FREQ,
      OP_INSTR,
      OP_VOLUME,
      OP_RHY_ENABLE,
      OP_RHY_BASS,
      OP_RHY_LEVEL
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_REDUCE,
      ST_FIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic reduce;
      logic fix;
      logic push;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic req_is_freq;
      logic slot_keep;
      logic slot_last;
      logic out_free;
   } dp_status_type;

   // register port
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;
   localparam logic RegChipMode = 1'b0;

   // source register map
   localparam logic [5:0] SrcRhythm = 6'h0e;
   localparam logic [5:0] SrcLevelA = 6'h37;
   localparam logic [5:0] SrcLevelB = 6'h38;
   localparam logic [5:0] SrcBass   = 6'h36;
   localparam logic [2:0] GrpVoice  = 3'b000;
   localparam logic [2:0] GrpFnum   = 3'b010;
   localparam logic [2:0] GrpFreq   = 3'b100;
   localparam logic [2:0] GrpChan   = 3'b110;
   localparam int ChanCount = 6;
   localparam int VoiceRegs = 8;

   // frequency scaling by a reciprocal multiply and one correction
   localparam int FnumWidth = 9;
   localparam int FreqWidth = 11;
   localparam int ProdWidth = 27;
   localparam int FreqShift = 16;
   localparam int unsigned FreqNum = 200000;
   localparam int unsigned FreqDen = 55467;
   localparam longint unsigned FreqRecipWide =
      (longint'(FreqNum) << FreqShift) / longint'(FreqDen);
   localparam logic [ProdWidth-1:0] FreqRecip = ProdWidth'(FreqRecipWide);
   localparam logic [ProdWidth-1:0] FreqNumP  = ProdWidth'(FreqNum);
   localparam logic [ProdWidth-1:0] FreqDenP  = ProdWidth'(FreqDen);

   localparam int VoiceCount = 16;
   localparam int VoiceBytes = 13;

   localparam logic [7:0] PresetVoices [VoiceCount][VoiceBytes] = '{
      '{8'h00,8'h00,8'h7F,8'h7f,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'hFF,8'hFF,8'h04},
      '{8'h01,8'h01,8'h25,8'h7f,8'h17,8'h0B,8'h09,8'h0D,8'h00,8'h00,8'h14,8'h17,8'h3C},
      '{8'h02,8'h01,8'h2B,8'h7f,8'h15,8'h15,8'h07,8'h07,8'h07,8'h07,8'h75,8'h05,8'h2C},
      '{8'h01,8'h01,8'h1D,8'h7f,8'h9B,8'h97,8'h13,8'h05,8'h00,8'h05,8'h11,8'hF4,8'h2C},
      '{8'h01,8'h01,8'h41,8'h7f,8'h0D,8'h89,8'h19,8'h07,8'h00,8'h00,8'h18,8'h26,8'h3C},
      '{8'h02,8'h00,8'h41,8'h7f,8'h11,8'h8B,8'h91,8'h09,8'h00,8'h00,8'h14,8'h06,8'h3C},
      '{8'h01,8'h04,8'h41,8'h7f,8'h8F,8'h8B,8'h05,8'h0D,8'h00,8'h00,8'h0A,8'h1C,8'h2C},
      '{8'h01,8'h01,8'h2D,8'h7f,8'h8B,8'h8B,8'h03,8'h05,8'h00,8'h00,8'h26,8'h24,8'h3C},
      '{8'h01,8'h03,8'h15,8'h7f,8'h1F,8'h1F,8'h99,8'h11,8'h00,8'h00,8'h28,8'h29,8'h34},
      '{8'h01,8'h01,8'h1B,8'h7f,8'h0F,8'h9F,8'h0B,8'h05,8'h00,8'h00,8'h18,8'h03,8'h2C},
      '{8'h02,8'h04,8'h17,8'h7f,8'h13,8'h17,8'h09,8'h01,8'h09,8'h01,8'h33,8'hF6,8'h34},
      '{8'h01,8'h00,8'h0D,8'h7f,8'h15,8'h1D,8'h07,8'h05,8'h07,8'h05,8'hF4,8'hF4,8'h34},
      '{8'h09,8'h01,8'h49,8'h7f,8'h93,8'h9B,8'h8B,8'h83,8'h00,8'h00,8'hE5,8'hF2,8'h34},
      '{8'h00,8'h01,8'h13,8'h7f,8'h19,8'h9F,8'h0F,8'h13,8'h0F,8'h00,8'h14,8'h04,8'h34},
      '{8'h01,8'h01,8'h23,8'h7f,8'h99,8'h97,8'h01,8'h05,8'h01,8'h05,8'h01,8'hF4,8'h04},
      '{8'h03,8'h03,8'h1F,8'h7f,8'h1B,8'h17,8'h1B,8'h1F,8'h00,8'h1F,8'h4A,8'h05,8'h3C}
   };

   function automatic logic [7:0] preset_byte(logic [3:0] row, logic [3:0] idx);
      logic [7:0] result;
      result = 8'h00;
      if (idx < 4'(VoiceBytes)) begin
         result = PresetVoices[row][idx];
      end
      return result;
   endfunction

   function automatic logic [7:0] level_byte(logic [3:0] nib);
      logic [5:0] atten;
      atten = 6'd63 - {1'b0, nib, 1'b0};
      return {2'b11, atten};
   endfunction

endpackage

### src/fmo_csr.sv
// configuration register block holding the target chip mode
module fmo_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fmo_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [fmo_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [fmo_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready,
   output fmo_pkg::chip_mode_type             chip_mode
);

   fmo_pkg::chip_mode_type mode_ff, mode_in;
   logic                   wr_en;
   logic                   reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      mode_in = mode_ff;
      if (wr_en && reg_idx == fmo_pkg::RegChipMode) begin
         if (pwdata[1:0] == 2'b11) begin
            mode_in = fmo_pkg::CHIP_BOTH;
         end else begin
            mode_in = fmo_pkg::chip_mode_type'(pwdata[1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fmo_pkg::CHIP_BOTH;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == fmo_pkg::RegChipMode) begin
         prdata = fmo_pkg::CsrDataWidth'(mode_ff);
      end
   end

   assign chip_mode = mode_ff;

endmodule

### src/fmo_ctrl.sv
// controller state machine sequencing accept, frequency scaling and write emission
module fmo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fmo_pkg::dp_status_type status,
   output fmo_pkg::dp_cmd_type    cmd
);

   fmo_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != fmo_pkg::ST_IDLE);
      unique case (state_ff)
         fmo_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_is_freq ? fmo_pkg::ST_MUL : fmo_pkg::ST_EMIT;
            end
         end
         fmo_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fmo_pkg::ST_REDUCE;
         end
         fmo_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = fmo_pkg::ST_FIX;
         end
         fmo_pkg::ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = fmo_pkg::ST_EMIT;
         end
         fmo_pkg::ST_EMIT: begin
            // dropped slots pass without waiting on the output register
            if (!status.slot_keep || status.out_free) begin
               cmd.advance = 1'b1;
               cmd.push    = status.slot_keep;
               if (status.slot_last) begin
                  state_in = fmo_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = fmo_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/fmo_dp.sv
// datapath: source shadow, frequency scaling, write slot generation and output register
module fmo_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  fmo_pkg::req_type       req_data,
   output fmo_pkg::rsp_type       rsp_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  fmo_pkg::chip_mode_type chip_mode,
   input  fmo_pkg::dp_cmd_type    cmd,
   output fmo_pkg::dp_status_type status
);

   localparam logic [4:0] SlotOpLast   = 5'd11;
   localparam logic [4:0] SlotZeroA    = 5'd12;
   localparam logic [4:0] SlotZeroB    = 5'd13;
   localparam logic [4:0] SlotFbAlg    = 5'd14;
   localparam logic [4:0] SlotPan      = 5'd15;
   localparam logic [4:0] SlotVolume   = 5'd16;
   localparam logic [4:0] SlotFreqLast = 5'd2;
   localparam logic [3:0] FbAlgIdx     = 4'd12;

   // shadow of the source registers that later translations read
   logic [7:0] voice_ff [fmo_pkg::VoiceRegs];
   logic [7:0] voice_in [fmo_pkg::VoiceRegs];
   logic [7:0] fnum_ff  [fmo_pkg::ChanCount];
   logic [7:0] fnum_in  [fmo_pkg::ChanCount];
   logic [3:0] inst_ff  [fmo_pkg::ChanCount];
   logic [3:0] inst_in  [fmo_pkg::ChanCount];
   logic       rhythm_ff, rhythm_in;

   // transaction in progress
   fmo_pkg::op_type op_ff, op_in;
   logic [5:0]      reg_ff, reg_in;
   logic [7:0]      val_ff, val_in;
   logic [4:0]      slot_ff, slot_in;

   // frequency pipeline
   logic [fmo_pkg::FnumWidth-1:0] fn_ff, fn_in;
   logic [fmo_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic [fmo_pkg::ProdWidth-1:0] num_ff, num_in;
   logic [fmo_pkg::ProdWidth-1:0] qm_ff, qm_in;
   logic [fmo_pkg::FreqWidth-1:0] qest_ff, qest_in;
   logic [fmo_pkg::FreqWidth-1:0] f_ff, f_in;
   logic [fmo_pkg::ProdWidth-1:0] rem;

   // output register
   fmo_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request decode
   logic [5:0]      rq_reg;
   logic [7:0]      rq_val;
   logic [2:0]      rq_ch;
   logic            rq_ch_ok;
   logic            rq_is_freq;
   logic            rq_is_chan;
   logic [7:0]      rq_fnum;
   logic [3:0]      rq_inst;
   fmo_pkg::op_type rq_op;

   // slot generation
   logic [2:0] ch;
   logic [2:0] code;
   logic [8:0] base;
   logic [3:0] row;
   logic [3:0] voice_idx;
   logic [7:0] voice_byte;
   logic [7:0] custom_v [fmo_pkg::VoiceBytes];
   logic [8:0] slot_addr;
   logic [7:0] slot_data;
   logic       slot_exists;
   logic       slot_last;
   logic       slot_keep;

   assign rq_reg     = req_data.src_register;
   assign rq_val     = req_data.write_value;
   assign rq_ch      = rq_reg[2:0];
   assign rq_ch_ok   = (rq_ch < 3'(fmo_pkg::ChanCount));
   assign rq_is_freq = (rq_reg[5:3] == fmo_pkg::GrpFreq) && rq_ch_ok;
   assign rq_is_chan = (rq_reg[5:3] == fmo_pkg::GrpChan) && rq_ch_ok;
   assign rq_fnum    = rq_ch_ok ? fnum_ff[rq_ch] : 8'h00;
   assign rq_inst    = rq_ch_ok ? inst_ff[rq_ch] : 4'h0;

   always_comb begin
      priority if (rq_is_freq) begin
         rq_op = fmo_pkg::OP_FREQ;
      end else if (rq_is_chan) begin
         rq_op = (rq_val[7:4] != rq_inst) ? fmo_pkg::OP_INSTR : fmo_pkg::OP_VOLUME;
      end else if (rq_reg == fmo_pkg::SrcRhythm) begin
         rq_op = rq_val[5] ? fmo_pkg::OP_RHY_ENABLE : fmo_pkg::OP_NONE;
      end else if (rq_reg == fmo_pkg::SrcBass) begin
         rq_op = rhythm_ff ? fmo_pkg::OP_RHY_BASS : fmo_pkg::OP_NONE;
      end else if (rq_reg == fmo_pkg::SrcLevelA || rq_reg == fmo_pkg::SrcLevelB) begin
         rq_op = rhythm_ff ? fmo_pkg::OP_RHY_LEVEL : fmo_pkg::OP_NONE;
      end else begin
         rq_op = fmo_pkg::OP_NONE;
      end
   end

   // load, shadow update and slot counter
   always_comb begin
      op_in     = op_ff;
      reg_in    = reg_ff;
      val_in    = val_ff;
      slot_in   = slot_ff;
      fn_in     = fn_ff;
      voice_in  = voice_ff;
      fnum_in   = fnum_ff;
      inst_in   = inst_ff;
      rhythm_in = rhythm_ff;
      if (cmd.load) begin
         op_in   = rq_op;
         reg_in  = rq_reg;
         val_in  = rq_val;
         slot_in = (rq_op == fmo_pkg::OP_VOLUME) ? SlotVolume : 5'd0;
         fn_in   = {rq_val[0], rq_fnum};
         if (rq_reg[5:3] == fmo_pkg::GrpVoice) begin
            voice_in[rq_ch] = rq_val;
         end
         if (rq_reg[5:3] == fmo_pkg::GrpFnum && rq_ch_ok) begin
            fnum_in[rq_ch] = rq_val;
         end
         if (rq_is_chan) begin
            inst_in[rq_ch] = rq_val[7:4];
         end
         if (rq_reg == fmo_pkg::SrcRhythm) begin
            rhythm_in = rq_val[5];
         end
      end else if (cmd.advance) begin
         slot_in = slot_ff + 5'd1;
      end
   end

   // frequency scaling: fn * num / den
   assign rem = num_ff - qm_ff;

   always_comb begin
      prod_in = prod_ff;
      num_in  = num_ff;
      qest_in = qest_ff;
      qm_in   = qm_ff;
      f_in    = f_ff;
      if (cmd.mul) begin
         prod_in = fmo_pkg::ProdWidth'(fn_ff) * fmo_pkg::FreqRecip;
         num_in  = fmo_pkg::ProdWidth'(fn_ff) * fmo_pkg::FreqNumP;
      end
      if (cmd.reduce) begin
         qest_in = prod_ff[fmo_pkg::FreqShift +: fmo_pkg::FreqWidth];
         qm_in   = fmo_pkg::ProdWidth'(prod_ff[fmo_pkg::FreqShift +: fmo_pkg::FreqWidth])
                   * fmo_pkg::FreqDenP;
      end
      if (cmd.fix) begin
         f_in = qest_ff + fmo_pkg::FreqWidth'(rem >= fmo_pkg::FreqDenP);
      end
   end

   // custom voice built from the first eight shadow registers
   always_comb begin
      custom_v[0]  = {4'h0, voice_ff[0][3:0]};
      custom_v[1]  = {4'h0, voice_ff[1][3:0]};
      custom_v[2]  = {1'b0, voice_ff[2][5:0], 1'b0};
      custom_v[3]  = 8'h7f;
      custom_v[4]  = {voice_ff[0][4], 2'b00, voice_ff[4][7:4], 1'b1};
      custom_v[5]  = {voice_ff[1][4], 2'b00, voice_ff[5][7:4], 1'b1};
      custom_v[6]  = {voice_ff[0][7], 2'b00, voice_ff[4][3:0], 1'b1};
      custom_v[7]  = {voice_ff[1][7], 2'b00, voice_ff[5][3:0], 1'b1};
      custom_v[8]  = voice_ff[0][5] ? 8'h00 : custom_v[6];
      custom_v[9]  = voice_ff[1][5] ? 8'h00 : custom_v[7];
      custom_v[10] = voice_ff[6];
      custom_v[11] = voice_ff[7];
      custom_v[12] = {2'b00, voice_ff[3][2:0], 3'b100};
   end

   assign ch        = reg_ff[2:0];
   assign base      = (ch > 3'd2) ? (9'h100 + 9'(ch - 3'd3)) : 9'(ch);
   assign code      = (ch > 3'd2) ? (ch + 3'd1) : ch;
   assign row       = val_ff[7:4];
   assign voice_idx = (slot_ff == SlotFbAlg) ? FbAlgIdx : slot_ff[3:0];

   always_comb begin
      voice_byte = fmo_pkg::preset_byte(row, voice_idx);
      if (row == 4'h0) begin
         voice_byte = (voice_idx < 4'(fmo_pkg::VoiceBytes)) ? custom_v[voice_idx] : 8'h00;
      end
   end

   always_comb begin
      slot_addr   = 9'h000;
      slot_data   = 8'h00;
      slot_exists = 1'b1;
      slot_last   = 1'b1;
      unique case (op_ff)
         fmo_pkg::OP_FREQ: begin
            slot_last = (slot_ff == SlotFreqLast);
            unique case (slot_ff)
               5'd0: begin
                  slot_addr = base + 9'h0a4;
                  slot_data = {2'b00, val_ff[3:1], f_ff[10:8]};
               end
               5'd1: begin
                  slot_addr = base + 9'h0a0;
                  slot_data = f_ff[7:0];
               end
               default: begin
                  slot_addr = 9'h028;
                  slot_data = {2'b00, val_ff[4], val_ff[4], 1'b0, code};
               end
            endcase
         end
         fmo_pkg::OP_INSTR, fmo_pkg::OP_VOLUME: begin
            slot_last = (slot_ff == SlotVolume);
            priority if (slot_ff <= SlotOpLast) begin
               slot_addr = base + 9'h030 + 9'({slot_ff[3:0], 3'b000});
               slot_data = voice_byte;
            end else if (slot_ff == SlotZeroA) begin
               slot_addr = base + 9'h090;
            end else if (slot_ff == SlotZeroB) begin
               slot_addr = base + 9'h098;
            end else if (slot_ff == SlotFbAlg) begin
               slot_addr = base + 9'h0b0;
               slot_data = voice_byte;
            end else if (slot_ff == SlotPan) begin
               slot_addr = base + 9'h0b4;
               slot_data = 8'hd0;
            end else begin
               slot_addr = base + 9'h048;
               slot_data = {1'b0, val_ff[3:0], 3'b000};
            end
         end
         fmo_pkg::OP_RHY_ENABLE: begin
            slot_addr = 9'h010;
            slot_data = {3'b000, val_ff[2], val_ff[0], val_ff[1], val_ff[3], val_ff[4]};
         end
         fmo_pkg::OP_RHY_BASS: begin
            slot_addr = 9'h018;
            slot_data = fmo_pkg::level_byte(val_ff[3:0]);
         end
         fmo_pkg::OP_RHY_LEVEL: begin
            slot_last = (slot_ff == 5'd1);
            if (slot_ff == 5'd0) begin
               slot_addr = (reg_ff == fmo_pkg::SrcLevelA) ? 9'h019 : 9'h01a;
               slot_data = fmo_pkg::level_byte(val_ff[3:0]);
            end else begin
               slot_addr = (reg_ff == fmo_pkg::SrcLevelA) ? 9'h01b : 9'h01c;
               slot_data = fmo_pkg::level_byte(val_ff[7:4]);
            end
         end
         default: begin
            slot_exists = 1'b0;
         end
      endcase
   end

   // writes to a bank the target chip lacks are dropped
   assign slot_keep = slot_exists && (chip_mode != fmo_pkg::CHIP_NONE)
                      && !(slot_addr[8] && chip_mode == fmo_pkg::CHIP_BASE);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.push) begin
         rsp_in.target_address = slot_addr;
         rsp_in.target_data    = slot_data;
         rsp_in.last_write     = slot_last;
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rhythm_ff    <= 1'b0;
         for (int i = 0; i < fmo_pkg::VoiceRegs; i++) begin
            voice_ff[i] <= 8'h00;
         end
         for (int i = 0; i < fmo_pkg::ChanCount; i++) begin
            fnum_ff[i] <= 8'h00;
            inst_ff[i] <= 4'h0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rhythm_ff    <= rhythm_in;
         voice_ff     <= voice_in;
         fnum_ff      <= fnum_in;
         inst_ff      <= inst_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      reg_ff  <= reg_in;
      val_ff  <= val_in;
      slot_ff <= slot_in;
      fn_ff   <= fn_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      qest_ff <= qest_in;
      qm_ff   <= qm_in;
      f_ff    <= f_in;
      rsp_ff  <= rsp_in;
   end

   assign status.req_is_freq = rq_is_freq;
   assign status.slot_keep   = slot_keep;
   assign status.slot_last   = slot_last;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/fm_opll_to_opn_register_translator.sv
// top level of the 2-operator to 4-operator fm register write translator
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | req_data  (src_register, write_value)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_data  (target_address, target_data,
//          |           |                         |            last_write)
//  csr     | in        | psel / penable / pready | paddr, pwdata, prdata (chip_mode)
//
// a transaction is accepted, then steps through its target write slots in order:
// seventeen for an instrument change, one for volume, rhythm or an unhandled register,
// two for rhythm levels and three for a frequency write after multiply, reduce and fix;
// dropped writes still take their slot; the single output register sets the pace
// reset is synchronous, clears the source shadow and selects both target banks
// rsp_stall holds the current write slot; req_stall stays high until the last slot is out
module fm_opll_to_opn_register_translator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fmo_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fmo_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fmo_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [fmo_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [fmo_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready
);

   fmo_pkg::chip_mode_type chip_mode;
   fmo_pkg::dp_cmd_type    cmd;
   fmo_pkg::dp_status_type status;

   fmo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .chip_mode (chip_mode)
   );

   fmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fmo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .chip_mode (chip_mode),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### src/fmo_checker.sv
// port-level checker for the fm register translator and its bind
`include "assert_macros.svh"

module fmo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fmo_pkg::rsp_type rsp_data
);

   logic held_ff;
   logic new_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= rsp_valid && rsp_stall;
      end
   end

   assign new_write = rsp_valid && !held_ff;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "no busy after accepted transaction")

   `ASSERT_IMPLY(a_mid_busy, clock, reset, new_write && !rsp_data.last_write, req_stall, "input taken before last write")

   `ASSERT_IMPLY(a_last_idle, clock, reset, new_write && rsp_data.last_write, !req_stall, "still busy after last write")

endmodule

bind fm_opll_to_opn_register_translator fmo_checker u_fmo_checker (.*);

### verif/fmo_write_checker.sv
// checker for the fm register translator: predicts target chip writes and compares them
module fmo_write_checker import fmo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  rsp_type                 rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output int                      mismatch_count,
   output int                      writes_due
);

   localparam logic [CsrAddrWidth-1:0] AddrChipMode = '0;

   // target chip register map
   localparam logic [8:0] OpnUpperBank = 9'h100;
   localparam logic [8:0] OpnRhythmKey = 9'h010;
   localparam logic [8:0] OpnBassLevel = 9'h018;
   localparam logic [8:0] OpnLevelLo   = 9'h019;
   localparam logic [8:0] OpnLevelHi   = 9'h01b;
   localparam logic [8:0] OpnKeyOn     = 9'h028;
   localparam logic [8:0] OpnOpFirst   = 9'h030;
   localparam logic [8:0] OpnVolume    = 9'h048;
   localparam logic [8:0] OpnOpZeroA   = 9'h090;
   localparam logic [8:0] OpnOpZeroB   = 9'h098;
   localparam logic [8:0] OpnFnumLow   = 9'h0a0;
   localparam logic [8:0] OpnFnumHigh  = 9'h0a4;
   localparam logic [8:0] OpnFbAlg     = 9'h0b0;
   localparam logic [8:0] OpnPan       = 9'h0b4;
   localparam logic [7:0] PanBoth      = 8'hd0;

   chip_mode_type mode_now;
   logic [7:0]    opll_shadow [64];
   logic [7:0]    voice_table [VoiceCount][VoiceBytes];
   rsp_type       opn_writes_due [$];
   rsp_type       batch [$];

   initial begin
      mismatch_count = 0;
      writes_due = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t fmo_write_checker: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [7:0] atten_code(input logic [3:0] nib);
      logic [5:0] steps;
      steps = 6'd63 - {1'b0, nib, 1'b0};
      return {2'b11, steps};
   endfunction

   task automatic emit(input logic [8:0] addr, input logic [7:0] data);
      if (mode_now != CHIP_NONE && !(addr[8] && mode_now == CHIP_BASE)) begin
         batch.push_back('{target_address: addr, target_data: data, last_write: 1'b0});
      end
   endtask

   task automatic translate_opll_write(input req_type item);
      logic [5:0]  r;
      logic [7:0]  v;
      logic [2:0]  ch;
      logic [2:0]  key_code;
      logic [8:0]  base;
      logic [8:0]  level_sel;
      logic [3:0]  row;
      int unsigned fnum;
      int unsigned freq;
      rsp_type     w;
      r = item.src_register;
      v = item.write_value;
      ch = r[2:0];
      base = (ch > 3'd2) ? OpnUpperBank + 9'(ch - 3'd3) : 9'(ch);
      key_code = (ch > 3'd2) ? ch + 3'd1 : ch;
      batch.delete();
      if (r[5:3] == GrpFreq && ch < ChanCount) begin
         fnum = {23'd0, v[0], opll_shadow[{GrpFnum, ch}]};
         freq = fnum * FreqNum / FreqDen;
         emit(base + OpnFnumHigh, {2'b00, v[3:1], freq[10:8]});
         emit(base + OpnFnumLow, freq[7:0]);
         emit(OpnKeyOn, {2'b00, v[4], v[4], 1'b0, key_code});
      end else if (r[5:3] == GrpChan && ch < ChanCount) begin
         if (v[7:4] != opll_shadow[r][7:4]) begin
            row = v[7:4];
            if (row == 4'd0) begin
               // custom voice from shadow registers 0 to 7
               voice_table[0][0]  = {4'h0, opll_shadow[0][3:0]};
               voice_table[0][1]  = {4'h0, opll_shadow[1][3:0]};
               voice_table[0][2]  = {1'b0, opll_shadow[2][5:0], 1'b0};
               voice_table[0][3]  = 8'h7f;
               voice_table[0][4]  = {opll_shadow[0][4], 2'b00, opll_shadow[4][7:4], 1'b1};
               voice_table[0][5]  = {opll_shadow[1][4], 2'b00, opll_shadow[5][7:4], 1'b1};
               voice_table[0][6]  = {opll_shadow[0][7], 2'b00, opll_shadow[4][3:0], 1'b1};
               voice_table[0][7]  = {opll_shadow[1][7], 2'b00, opll_shadow[5][3:0], 1'b1};
               voice_table[0][8]  = opll_shadow[0][5] ? 8'h00 : voice_table[0][6];
               voice_table[0][9]  = opll_shadow[1][5] ? 8'h00 : voice_table[0][7];
               voice_table[0][10] = opll_shadow[6];
               voice_table[0][11] = opll_shadow[7];
               voice_table[0][12] = {2'b00, opll_shadow[3][2:0], 3'b100};
            end
            for (int k = 0; k < 12; k++) begin
               emit(base + OpnOpFirst + 9'(8 * k), voice_table[row][k]);
            end
            emit(base + OpnOpZeroA, 8'h00);
            emit(base + OpnOpZeroB, 8'h00);
            emit(base + OpnFbAlg, voice_table[row][12]);
            emit(base + OpnPan, PanBoth);
         end
         emit(base + OpnVolume, {1'b0, v[3:0], 3'b000});
      end else if (r == SrcRhythm) begin
         if (v[5]) begin
            emit(OpnRhythmKey, {3'b000, v[2], v[0], v[1], v[3], v[4]});
         end
      end else if (r == SrcBass) begin
         if (opll_shadow[SrcRhythm][5]) begin
            emit(OpnBassLevel, atten_code(v[3:0]));
         end
      end else if (r == SrcLevelA || r == SrcLevelB) begin
         if (opll_shadow[SrcRhythm][5]) begin
            level_sel = (r == SrcLevelB) ? 9'd1 : 9'd0;
            emit(OpnLevelLo + level_sel, atten_code(v[3:0]));
            emit(OpnLevelHi + level_sel, atten_code(v[7:4]));
         end
      end
      opll_shadow[r] = v;
      foreach (batch[i]) begin
         w = batch[i];
         w.last_write = (i == batch.size() - 1);
         opn_writes_due.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode_now = CHIP_BOTH;
         foreach (opll_shadow[i]) opll_shadow[i] = 8'h00;
         voice_table = PresetVoices;
         opn_writes_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == AddrChipMode) begin
            mode_now = (pwdata[1:0] == 2'd3) ? CHIP_BOTH : chip_mode_type'(pwdata[1:0]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (opn_writes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected write addr %h data %h last %b",
                  rsp_data.target_address, rsp_data.target_data, rsp_data.last_write));
            end else begin
               want = opn_writes_due.pop_front();
               if (rsp_data.target_address !== want.target_address)
                  report_mismatch($sformatf("address %h, expected %h",
                     rsp_data.target_address, want.target_address));
               if (rsp_data.target_data !== want.target_data)
                  report_mismatch($sformatf("data %h at %h, expected %h",
                     rsp_data.target_data, want.target_address, want.target_data));
               if (rsp_data.last_write !== want.last_write)
                  report_mismatch($sformatf("last flag %b at %h, expected %b",
                     rsp_data.last_write, want.target_address, want.last_write));
            end
         end
         if (req_valid && !req_stall) begin
            translate_opll_write(req_data);
         end
      end
      writes_due = opn_writes_due.size();
   end

endmodule

### verif/tb_fm_opll_to_opn_register_translator.sv
// testbench top of the fm register translator: stimulus, idling and verdict
module tb_fm_opll_to_opn_register_translator;
   import fmo_pkg::*;

   localparam logic [CsrAddrWidth-1:0] AddrChipMode = '0;
   localparam logic [1:0] ChipModeWrap = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   int         fail_count;
   int         writes_due;
   bit         idle_on = 1'b1;
   int         stall_left = 0;
   logic [7:0] last_value [64];
   logic [1:0] phase_mode [4] = '{CHIP_BASE, CHIP_NONE, ChipModeWrap, CHIP_BOTH};
   int         phase_len [4] = '{70, 40, 70, 130};

   always #5 clock = ~clock;

   fm_opll_to_opn_register_translator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fmo_write_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (fail_count),
      .writes_due     (writes_due)
   );

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr, input logic [1:0] mode);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= {30'($urandom), mode};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      last_value[item.src_register] = item.write_value;
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (writes_due == 0);
   endtask

   // also covers writes that were all dropped but still occupy the block
   task automatic settle();
      drain();
      repeat (24) @(negedge clock);
   endtask

   task automatic run_item(input req_type item);
      if (idle_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 13));
      send(item);
   endtask

   function automatic req_type write_of(input logic [5:0] r, input logic [7:0] v);
      return '{src_register: r, write_value: v};
   endfunction

   function automatic req_type random_item();
      int         pick;
      logic [2:0] ch;
      logic [5:0] r;
      logic [7:0] v;
      pick = $urandom_range(0, 99);
      ch = 3'($urandom_range(0, ChanCount - 1));
      v = 8'($urandom);
      if (pick < 30) begin
         r = {GrpChan, ch};
         if ($urandom_range(0, 3) == 0) v[7:4] = last_value[r][7:4];
         else if ($urandom_range(0, 5) == 0) v[7:4] = 4'h0;
      end else if (pick < 50) begin
         r = {GrpFreq, ch};
      end else if (pick < 60) begin
         r = {GrpFnum, ch};
      end else if (pick < 68) begin
         r = {GrpVoice, 3'($urandom_range(0, VoiceRegs - 1))};
      end else if (pick < 75) begin
         r = SrcRhythm;
         if ($urandom_range(0, 2) != 0) v[5] = 1'b1;
      end else if (pick < 85) begin
         r = SrcBass + 6'($urandom_range(0, 2));
      end else begin
         r = 6'($urandom_range(0, 63));
      end
      return write_of(r, v);
   endfunction

   initial begin
      #10_000_000;
      $display("tb_fm_opll_to_opn_register_translator NOT OK");
      $finish;
   end

   initial begin
      foreach (last_value[j]) last_value[j] = 8'h00;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      csr_write(AddrChipMode, CHIP_BOTH);

      // custom voice source registers
      run_item(write_of({GrpVoice, 3'd0}, 8'ha5));
      run_item(write_of({GrpVoice, 3'd1}, 8'h5a));
      run_item(write_of({GrpVoice, 3'd2}, 8'hff));
      run_item(write_of({GrpVoice, 3'd3}, 8'h07));
      run_item(write_of({GrpVoice, 3'd4}, 8'hf0));
      run_item(write_of({GrpVoice, 3'd5}, 8'h0f));
      run_item(write_of({GrpVoice, 3'd6}, 8'h80));
      run_item(write_of({GrpVoice, 3'd7}, 8'h7f));
      // frequency and key-on, base and upper bank
      run_item(write_of({GrpFnum, 3'd0}, 8'hff));
      run_item(write_of({GrpFreq, 3'd0}, 8'h1f));
      run_item(write_of({GrpFreq, 3'd5}, 8'h00));
      drain();
      // same instrument, preset change, custom voice on the upper bank
      run_item(write_of({GrpChan, 3'd0}, 8'h0f));
      run_item(write_of({GrpChan, 3'd3}, 8'hf5));
      run_item(write_of({GrpChan, 3'd3}, 8'h0a));
      run_item(write_of({GrpChan, 3'd1}, 8'h1f));
      // rhythm levels while off, then on
      run_item(write_of(SrcBass, 8'hff));
      run_item(write_of(SrcLevelA, 8'hab));
      run_item(write_of(SrcRhythm, 8'h3f));
      run_item(write_of(SrcBass, 8'h0f));
      run_item(write_of(SrcLevelA, 8'hf0));
      run_item(write_of(SrcLevelB, 8'h5a));
      run_item(write_of(SrcRhythm, 8'h1f));
      run_item(write_of(SrcLevelB, 8'h00));
      run_item(write_of(6'h3f, 8'hff));
      settle();

      for (int p = 0; p < 4; p++) begin
         csr_write(AddrChipMode, phase_mode[p]);
         repeat (phase_len[p]) begin
            if ($urandom_range(0, 19) == 0) idle_on = ($urandom_range(0, 2) != 0);
            run_item(random_item());
            if ($urandom_range(0, 49) == 0) drain();
         end
         settle();
      end

      idle_on = 1'b0;
      csr_write(AddrChipMode, CHIP_BOTH);
      repeat (75) run_item(random_item());
      drain();
      repeat (30) @(negedge clock);

      if (fail_count == 0 && writes_due == 0) begin
         $display("tb_fm_opll_to_opn_register_translator OK");
      end else begin
         $display("tb_fm_opll_to_opn_register_translator NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/fmo_pkg.sv
src/fmo_csr.sv
src/fmo_ctrl.sv
src/fmo_dp.sv
src/fm_opll_to_opn_register_translator.sv
src/fmo_checker.sv
verif/fmo_write_checker.sv
verif/tb_fm_opll_to_opn_register_translator.sv
